// File: rtl/core/hlnv_pkg.sv
// Shared types and constants for the held LFSR noise block.
// Used by the front, queue, back and top modules; depends on nothing.
package hlnv_pkg;

   localparam int SAMPLE_RATE_W = 19;
   localparam int SEED_W        = 32;
   localparam int LEN_W         = 7;
   localparam int FREQ_W        = 32;
   localparam int TAP_W         = 5;
   localparam int PERIOD_W      = 32;
   localparam int FRAC_W        = 16;
   localparam int DVD_W         = SAMPLE_RATE_W + FRAC_W;
   localparam int DIV_STEPS     = DVD_W;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam int MAX_BLOCK_DEF = 64;

   localparam logic [FREQ_W-1:0]        FREQ_FLOOR        = FREQ_W'(66);
   localparam logic [SAMPLE_RATE_W-1:0] SAMPLE_RATE_RESET = SAMPLE_RATE_W'(48000);
   localparam logic [SEED_W-1:0]        SEED_RESET        = '1;

   localparam logic REG_SAMPLE_RATE = 1'b0;
   localparam logic REG_SEED_WORD   = 1'b1;

   localparam logic signed [1:0] LEVEL_POS = 2'sb01;
   localparam logic signed [1:0] LEVEL_NEG = 2'sb11;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic [LEN_W-1:0]    len;
      logic [PERIOD_W-1:0] period;
      logic [TAP_W-1:0]    tap;
   } queue_entry_type;

endpackage

// File: rtl/core/hlnv_front.sv
// Request front end: clamps the request, computes the hold period with a
// bit-serial restoring divider and pushes the job. Depends on hlnv_pkg.
module hlnv_front
   import hlnv_pkg::*;
#(
   parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [LEN_W-1:0]         req_block_length,
   input  logic [FREQ_W-1:0]        req_frequency,
   input  logic [TAP_W-1:0]         req_tap_position,
   input  logic [SAMPLE_RATE_W-1:0] sample_rate,
   output logic                     push_valid,
   input  logic                     push_ready,
   output queue_entry_type          push_entry
);

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} state_type;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK);

   state_type             state_ff, state_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [TAP_W-1:0]      tap_ff, tap_in;
   logic [FREQ_W-1:0]     div_ff, div_in;
   logic [FREQ_W-1:0]     rem_ff, rem_in;
   logic [DVD_W-1:0]      dvd_ff, dvd_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [FREQ_W:0]       trial;
   logic [LEN_W-1:0]      len_clamp;

   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign trial      = {rem_ff, dvd_ff[DVD_W-1]};
   assign len_clamp  = (req_block_length > MAX_LEN) ? MAX_LEN : req_block_length;

   always_comb begin
      push_entry.len    = len_ff;
      push_entry.tap    = tap_ff;
      push_entry.period = (dvd_ff == '0) ? PERIOD_W'(1) : dvd_ff[PERIOD_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      tap_in   = tap_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               len_in = len_clamp;
               tap_in = (req_tap_position == '0) ? TAP_W'(1) : req_tap_position;
               div_in = (req_frequency < FREQ_FLOOR) ? FREQ_FLOOR : req_frequency;
               rem_in = '0;
               dvd_in = {sample_rate, FRAC_W'(0)};
               cnt_in = '0;
               if (len_clamp != '0) begin
                  state_in = F_DIV;
               end
            end
         end
         F_DIV: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = FREQ_W'(trial - {1'b0, div_ff});
               dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[FREQ_W-1:0];
               dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      len_ff <= len_in;
      tap_ff <= tap_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

endmodule

// File: rtl/core/hlnv_queue.sv
// Two-entry job queue between front end and sample generator.
// Depends on hlnv_pkg.
module hlnv_queue
   import hlnv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  queue_entry_type push_entry,
   output logic            pop_valid,
   input  logic            pop_ready,
   output queue_entry_type pop_entry
);

   queue_entry_type    mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/hlnv_back.sv
// Sample generator: hold counter, variable-tap LFSR and registered output.
// Depends on hlnv_pkg.
module hlnv_back
   import hlnv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [SEED_W-1:0]        seed_word,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  queue_entry_type          pop_entry,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [1:0]        rsp_level,
   output logic                     rsp_last_sample
);

   logic                    busy_ff, busy_in;
   queue_entry_type         job_ff, job_in;
   logic [LEN_W-1:0]        k_ff, k_in;
   logic [SEED_W-1:0]       lfsr_ff, lfsr_in;
   logic [PERIOD_W-1:0]     hold_ff, hold_in;
   logic signed [1:0]       level_ff, level_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [1:0]       out_level_ff, out_level_in;
   logic                    out_last_ff, out_last_in;
   logic                    advance, last;
   logic [SEED_W-1:0]       src, shifted;

   assign pop_ready       = !busy_ff;
   assign advance         = busy_ff && (!out_valid_ff || rsp_ready);
   assign last            = (k_ff + LEN_W'(1) == job_ff.len);
   assign rsp_valid       = out_valid_ff;
   assign rsp_level       = out_level_ff;
   assign rsp_last_sample = out_last_ff;

   always_comb begin
      src     = (lfsr_ff == '0) ? seed_word : lfsr_ff;
      shifted = src >> 1;
      shifted[job_ff.tap] = src[0] ^ src[1];
   end

   always_comb begin
      busy_in      = busy_ff;
      job_in       = job_ff;
      k_in         = k_ff;
      lfsr_in      = lfsr_ff;
      hold_in      = hold_ff;
      level_in     = level_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_level_in = out_level_ff;
      out_last_in  = out_last_ff;
      if (!busy_ff) begin
         if (pop_valid) begin
            busy_in = 1'b1;
            job_in  = pop_entry;
            k_in    = '0;
         end
      end else if (advance) begin
         if (hold_ff == '0) begin
            hold_in  = job_ff.period - PERIOD_W'(1);
            lfsr_in  = shifted;
            level_in = shifted[0] ? LEVEL_POS : LEVEL_NEG;
         end else begin
            hold_in = hold_ff - PERIOD_W'(1);
         end
         out_valid_in = 1'b1;
         out_level_in = (hold_ff == '0) ? (shifted[0] ? LEVEL_POS : LEVEL_NEG) : level_ff;
         out_last_in  = last;
         k_in         = k_ff + LEN_W'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         lfsr_ff      <= SEED_RESET;
         hold_ff      <= '0;
         level_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         lfsr_ff      <= lfsr_in;
         hold_ff      <= hold_in;
         level_ff     <= level_in;
      end
      job_ff       <= job_in;
      k_ff         <= k_in;
      out_level_ff <= out_level_in;
      out_last_ff  <= out_last_in;
   end

endmodule

// File: rtl/core/held_lfsr_noise_variable_tap_top.sv
// Top level of the held LFSR noise block: register port and the three stages.
// Depends on hlnv_pkg, hlnv_front, hlnv_queue and hlnv_back.
//
// Each request yields block_length samples (saturated to MAX_BLOCK, none for
// zero), one per cycle while rsp_ready is high; the generator goes idle
// between blocks, as it pops the next job only after the last sample. The
// front end takes no new request while its bit-serial 35-step hold-period
// divider works or its job waits to be pushed; a two-entry queue lets that
// work overlap the sample output of earlier requests. Write the registers
// only while no request is in flight.
module held_lfsr_noise_variable_tap_top
   import hlnv_pkg::*;
#(
   parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [LEN_W-1:0]       req_block_length,
   input  logic [FREQ_W-1:0]      req_frequency,
   input  logic [TAP_W-1:0]       req_tap_position,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [1:0]      rsp_level,
   output logic                   rsp_last_sample,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   logic [SAMPLE_RATE_W-1:0] sample_rate_ff;
   logic [SEED_W-1:0]        seed_word_ff;
   logic                     csr_wr;
   logic                     push_valid, push_ready, pop_valid, pop_ready;
   queue_entry_type          push_entry, pop_entry;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      case (paddr[2])
         REG_SAMPLE_RATE: prdata = CSR_DATA_W'(sample_rate_ff);
         REG_SEED_WORD:   prdata = CSR_DATA_W'(seed_word_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= SAMPLE_RATE_RESET;
         seed_word_ff   <= SEED_RESET;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_SAMPLE_RATE: sample_rate_ff <= pwdata[SAMPLE_RATE_W-1:0];
            REG_SEED_WORD:   seed_word_ff   <= pwdata[SEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hlnv_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_block_length (req_block_length),
      .req_frequency    (req_frequency),
      .req_tap_position (req_tap_position),
      .sample_rate      (sample_rate_ff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   hlnv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   hlnv_back u_back (
      .clock           (clock),
      .reset           (reset),
      .seed_word       (seed_word_ff),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_level       (rsp_level),
      .rsp_last_sample (rsp_last_sample)
   );

   a_level_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level == LEVEL_POS || rsp_level == LEVEL_NEG))
      else $error("sample level is neither +1 nor -1");

   a_front_exclusive: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !push_valid)
      else $error("front end takes a request while pushing a job");

   a_popped_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |-> (pop_entry.len != '0 && pop_entry.period != '0))
      else $error("empty job or zero hold period reached the generator");

endmodule

// File: sim/hlnv_sample_checker.sv
`timescale 1ns / 1ps
// Sample checker for the held LFSR noise block: follows register writes, predicts
// the samples of every accepted request and compares them in order.
// Depends on hlnv_pkg only.
module hlnv_sample_checker
   import hlnv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [LEN_W-1:0]      req_block_length,
   input  logic [FREQ_W-1:0]     req_frequency,
   input  logic [TAP_W-1:0]      req_tap_position,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic signed [1:0]     rsp_level,
   input  logic                  rsp_last_sample,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    requests_seen,
   output int                    samples_seen
);

   typedef struct packed {
      logic [1:0] level;
      logic       last_sample;
   } sample_type;

   sample_type expected_samples[$];

   logic [SAMPLE_RATE_W-1:0] rate_hz;
   logic [SEED_W-1:0]        seed_value;
   logic [31:0]              noise_word;
   logic [PERIOD_W-1:0]      hold_left;
   logic [1:0]               level_now;
   int                       fail_tally = 0;
   int                       request_tally = 0;
   int                       sample_tally = 0;

   function automatic logic [PERIOD_W-1:0] hold_period_for(input logic [FREQ_W-1:0] freq);
      logic [63:0] divisor;
      logic [63:0] period;
      divisor = (freq < FREQ_FLOOR) ? 64'(FREQ_FLOOR) : 64'(freq);
      period  = (64'(rate_hz) << FRAC_W) / divisor;
      if (period == 64'd0) period = 64'd1;
      return period[PERIOD_W-1:0];
   endfunction

   task automatic predict_block(input logic [LEN_W-1:0]  len_in,
                                input logic [FREQ_W-1:0] freq,
                                input logic [TAP_W-1:0]  tap_in);
      int          count;
      int          tap;
      logic [31:0] word;
      logic        feedback;
      sample_type  entry;
      count = (int'(len_in) > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : int'(len_in);
      tap   = (tap_in == '0) ? 1 : int'(tap_in);
      for (int k = 0; k < count; k++) begin
         if (hold_left == '0) begin
            hold_left  = hold_period_for(freq);
            word       = (noise_word == '0) ? seed_value : noise_word;
            feedback   = word[0] ^ word[1];
            word       = word >> 1;
            word[tap]  = feedback;
            noise_word = word;
            level_now  = word[0] ? LEVEL_POS : LEVEL_NEG;
         end
         entry.level       = level_now;
         entry.last_sample = (k == count - 1);
         expected_samples.push_back(entry);
         hold_left = hold_left - PERIOD_W'(1);
      end
   endtask

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         rate_hz    = SAMPLE_RATE_RESET;
         seed_value = SEED_RESET;
         noise_word = '1;
         hold_left  = '0;
         level_now  = '0;
         expected_samples.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_ADDR_W-1:2] == REG_SAMPLE_RATE)
               rate_hz = pwdata[SAMPLE_RATE_W-1:0];
            else if (paddr[CSR_ADDR_W-1:2] == REG_SEED_WORD)
               seed_value = pwdata[SEED_W-1:0];
         end
         if (req_valid && req_ready) begin
            predict_block(req_block_length, req_frequency, req_tap_position);
            request_tally++;
         end
         if (rsp_valid && rsp_ready) begin
            sample_tally++;
            if (expected_samples.size() == 0) begin
               $error("unexpected sample: level %0d, last_sample %0b",
                      rsp_level, rsp_last_sample);
               fail_tally++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_level !== $signed(want.level)) begin
                  $error("level: expected %0d, actual %0d", $signed(want.level), rsp_level);
                  fail_tally++;
               end
               if (rsp_last_sample !== want.last_sample) begin
                  $error("last_sample: expected %0b, actual %0b",
                         want.last_sample, rsp_last_sample);
                  fail_tally++;
               end
            end
         end
      end
      mismatch_count <= fail_tally;
      pending_count  <= expected_samples.size();
      requests_seen  <= request_tally;
      samples_seen   <= sample_tally;
   end

endmodule

// File: sim/tb_held_lfsr_noise_variable_tap_top.sv
`timescale 1ns / 1ps
// Testbench top for held_lfsr_noise_variable_tap_top: drives requests and register
// writes with random idling and back-pressure; verdict comes from hlnv_sample_checker.
// Depends on hlnv_pkg, the block and the checker.
module tb_held_lfsr_noise_variable_tap_top;
   import hlnv_pkg::*;

   localparam int DRAIN_CYCLES    = 200;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 4000;
   localparam int RANDOM_PHASES   = 5;
   localparam int ITEMS_PER_PHASE = 19;
   localparam int IDLE_PERCENT    = 26;
   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [LEN_W-1:0]      req_block_length = '0;
   logic [FREQ_W-1:0]     req_frequency = '0;
   logic [TAP_W-1:0]      req_tap_position = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [1:0]     rsp_level;
   logic                  rsp_last_sample;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic quiet = 1'b0;
   logic stall_request = 1'b0;
   int   mismatch_count;
   int   pending_count;
   int   requests_seen;
   int   samples_seen;
   int   write_count = 0;

   always #5 clock = ~clock;

   held_lfsr_noise_variable_tap_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_block_length (req_block_length),
      .req_frequency    (req_frequency),
      .req_tap_position (req_tap_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_level        (rsp_level),
      .rsp_last_sample  (rsp_last_sample),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   hlnv_sample_checker sample_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_block_length (req_block_length),
      .req_frequency    (req_frequency),
      .req_tap_position (req_tap_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_level        (rsp_level),
      .rsp_last_sample  (rsp_last_sample),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .requests_seen    (requests_seen),
      .samples_seen     (samples_seen)
   );

   task automatic write_reg(input logic idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      write_count++;
      @(posedge clock);
   endtask

   task automatic push_request(input logic [LEN_W-1:0]  len,
                               input logic [FREQ_W-1:0] freq,
                               input logic [TAP_W-1:0]  tap);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_block_length <= len;
      req_frequency    <= freq;
      req_tap_position <= tap;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // empty requests leave no samples behind, so allow the pipeline to drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [LEN_W-1:0] random_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) return '0;
      if (pick < 9) return LEN_W'($urandom_range(127, 65));
      return LEN_W'($urandom_range(64, 1));
   endfunction

   // keep hold periods short unless the rate is tiny
   function automatic logic [FREQ_W-1:0] random_frequency(input bit allow_slow);
      logic [FREQ_W-1:0] f;
      f = FREQ_W'($urandom());
      if (allow_slow && $urandom_range(7) == 0)
         f = FREQ_W'($urandom_range(100));
      else if (f[31:26] == '0)
         f[31] = 1'b1;
      return f;
   endfunction

   initial begin : rsp_side
      bit stall_served;
      stall_served = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request && !stall_served) begin
            stall_served = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [SAMPLE_RATE_W-1:0] rate_pick;
      logic [SEED_W-1:0]        seed_pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero seed: tap 31 for 32 steps, then tap 30 once, clears the all-ones word
      write_reg(REG_SEED_WORD, '0);
      push_request(7'd32, FREQ_MAX, 5'd31);
      push_request(7'd1, FREQ_MAX, 5'd30);
      push_request(7'd8, 32'h8000_0000, 5'd0);
      settle();

      write_reg(REG_SEED_WORD, '1);
      push_request(7'd1, FREQ_MAX, 5'd0);
      push_request(7'd127, FREQ_MAX, 5'd1);
      push_request(7'd0, FREQ_W'($urandom()), TAP_W'($urandom()));
      push_request(7'd64, 32'd629145600, 5'd16);
      push_request(7'd65, 32'h5555_5555, 5'd21);
      push_request(7'd2, 32'hAAAA_AAAA, 5'd10);
      settle();

      write_reg(REG_SAMPLE_RATE, '0);
      write_reg(REG_SEED_WORD, CSR_DATA_W'($urandom()));
      push_request(7'd16, 32'd1, 5'd7);
      push_request(7'd20, 32'h1234_5678, 5'd31);
      settle();

      write_reg(REG_SAMPLE_RATE, 32'h0007_FFFF);
      push_request(7'd64, FREQ_MAX, 5'd2);
      push_request(7'd64, 32'hFFFF_0000, 5'd3);
      settle();

      write_reg(REG_SAMPLE_RATE, 32'd1);
      push_request(7'd64, 32'd0, 5'd31);
      push_request(7'd12, 32'd65, 5'd4);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         seed_pick = SEED_W'($urandom());
         case (ph)
            0: rate_pick = 19'd1;
            1: rate_pick = 19'd384000;
            2: begin
               rate_pick = SAMPLE_RATE_W'($urandom_range(384000, 1));
               seed_pick = '0;
            end
            3: rate_pick = 19'd48000;
            default: begin
               rate_pick = '1;
               seed_pick = '1;
            end
         endcase
         write_reg(REG_SAMPLE_RATE, CSR_DATA_W'(rate_pick));
         write_reg(REG_SEED_WORD, seed_pick);
         quiet         <= (ph == 1);
         stall_request <= (ph == 3);
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            push_request(random_length(), random_frequency(ph == 0), TAP_W'($urandom_range(31)));
      end
      settle();

      $display("Covered %0d requests and %0d samples over %0d register writes,", requests_seen,
               samples_seen, write_count);
      $display("incl. zero seed, zero and full-scale rates, empty and saturated blocks.");
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
